// ===== hw/rtl/fbpf_pkg.sv =====
`timescale 1ns / 1ps

package fbpf_pkg;

  // APB configuration port
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_EDGE_LOW  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_EDGE_MID  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_EDGE_HIGH = 2'd2;

  // Fixed field widths
  localparam int EDGE_W  = 16;
  localparam int FRAC_W  = 16;
  localparam int RATIO_W = 32;

  localparam int NUM_BANDS = 4;
  localparam int NUM_RATIOS = 3;

  localparam logic [1:0] BAND_0 = 2'd0;
  localparam logic [1:0] BAND_1 = 2'd1;
  localparam logic [1:0] BAND_2 = 2'd2;
  localparam logic [1:0] BAND_3 = 2'd3;

  typedef struct packed {
    logic [EDGE_W-1:0] low;
    logic [EDGE_W-1:0] mid;
    logic [EDGE_W-1:0] high;
  } fbpf_edges_t;

  // Controller to datapath commands
  typedef struct packed {
    logic search;    // ordinary sample, other than the first of a run, takes part in the peak search
    logic capture;   // last sample: snapshot peaks, clear bests, arm divider
    logic div_step;  // one restoring-division step on every ratio lane
    logic load_out;  // move finished result into the output register
  } fbpf_cmd_t;

endpackage

// ===== hw/rtl/fbpf_sample_if.sv =====
`timescale 1ns / 1ps

interface fbpf_sample_if import fbpf_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                    valid;
  logic                    ready;
  logic [SAMPLE_WIDTH-1:0] sample_x;
  logic [SAMPLE_WIDTH-1:0] sample_y;
  logic                    sample_last;

  modport source (output valid, output sample_x, output sample_y, output sample_last,
                  input ready);
  modport sink   (input valid, input sample_x, input sample_y, input sample_last,
                  output ready);
endinterface

// ===== hw/rtl/fbpf_result_if.sv =====
`timescale 1ns / 1ps

interface fbpf_result_if import fbpf_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                    valid;
  logic                    ready;
  logic [SAMPLE_WIDTH-1:0] peak_pos0;
  logic [SAMPLE_WIDTH-1:0] peak_pos1;
  logic [SAMPLE_WIDTH-1:0] peak_pos2;
  logic [SAMPLE_WIDTH-1:0] peak_pos3;
  logic [SAMPLE_WIDTH-1:0] peak_val0;
  logic [SAMPLE_WIDTH-1:0] peak_val1;
  logic [SAMPLE_WIDTH-1:0] peak_val2;
  logic [SAMPLE_WIDTH-1:0] peak_val3;
  logic [RATIO_W-1:0]      ratio_band0;
  logic [RATIO_W-1:0]      ratio_band1;
  logic [RATIO_W-1:0]      ratio_band3;
  logic                    ratio_invalid;

  modport source (output valid, output peak_pos0, output peak_pos1, output peak_pos2,
                  output peak_pos3, output peak_val0, output peak_val1, output peak_val2,
                  output peak_val3, output ratio_band0, output ratio_band1,
                  output ratio_band3, output ratio_invalid, input ready);
  modport sink   (input valid, input peak_pos0, input peak_pos1, input peak_pos2,
                  input peak_pos3, input peak_val0, input peak_val1, input peak_val2,
                  input peak_val3, input ratio_band0, input ratio_band1,
                  input ratio_band3, input ratio_invalid, output ready);
endinterface

// ===== hw/rtl/fbpf_apb_regs.sv =====
`timescale 1ns / 1ps

module fbpf_apb_regs import fbpf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output fbpf_edges_t        edges_o
);

  fbpf_edges_t            edges_q;
  logic [REG_IDX_W-1:0]   reg_idx;
  logic                   wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edges_q <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_EDGE_LOW:  edges_q.low  <= pwdata[EDGE_W-1:0];
        REG_EDGE_MID:  edges_q.mid  <= pwdata[EDGE_W-1:0];
        REG_EDGE_HIGH: edges_q.high <= pwdata[EDGE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_EDGE_LOW:  prdata = PDATA_W'(edges_q.low);
      REG_EDGE_MID:  prdata = PDATA_W'(edges_q.mid);
      REG_EDGE_HIGH: prdata = PDATA_W'(edges_q.high);
      default:       prdata = '0;
    endcase
  end

  assign edges_o = edges_q;

endmodule

// ===== hw/rtl/fbpf_ctrl.sv =====
`timescale 1ns / 1ps

module fbpf_ctrl import fbpf_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_last_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output fbpf_cmd_t cmd_o
);

  localparam int QW    = SAMPLE_WIDTH + FRAC_W;
  localparam int CNT_W = $clog2(QW);

  localparam logic [1:0] S_RUN  = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             run_start_q, run_start_d;
  logic             out_valid_q, out_valid_d;
  logic             in_acc;
  fbpf_cmd_t        cmd;

  assign in_ready_o = (state_q == S_RUN);
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    run_start_d = run_start_q;
    out_valid_d = out_valid_q;
    cmd         = '0;

    // drop the result flag once the sink takes it
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_RUN: begin
        if (in_acc) begin
          run_start_d = in_last_i;
          if (in_last_i) begin
            cmd.capture = 1'b1;
            cnt_d       = CNT_W'(QW - 1);
            state_d     = S_DIV;
          end else begin
            cmd.search = !run_start_q;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_d        = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd.load_out = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_RUN;
        end
      end
      default: begin
        state_d = S_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_RUN;
      cnt_q       <= '0;
      run_start_q <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      run_start_q <= run_start_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

`ifndef NO_ASSERTIONS
  a_capture_arms_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.capture |=> (state_q == S_DIV) && (cnt_q == CNT_W'(QW - 1)))
    else $error("division not armed after last sample");

  a_div_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) && (cnt_q == '0) |=> (state_q == S_DONE))
    else $error("division did not finish on its final step");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten before transfer");

  a_cmd_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.search, cmd.capture, cmd.div_step, cmd.load_out}))
    else $error("conflicting datapath commands");
`endif

endmodule

// ===== hw/rtl/fbpf_dpath.sv =====
`timescale 1ns / 1ps

module fbpf_dpath import fbpf_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  fbpf_edges_t             edges_i,
  input  fbpf_cmd_t               cmd_i,
  input  logic [SAMPLE_WIDTH-1:0] sample_x_i,
  input  logic [SAMPLE_WIDTH-1:0] sample_y_i,
  output logic [SAMPLE_WIDTH-1:0] peak_pos_o [NUM_BANDS],
  output logic [SAMPLE_WIDTH-1:0] peak_val_o [NUM_BANDS],
  output logic [RATIO_W-1:0]      ratio_o [NUM_RATIOS],
  output logic                    ratio_invalid_o
);

  localparam int W  = SAMPLE_WIDTH;
  localparam int CW = (W > EDGE_W) ? W : EDGE_W;
  localparam int QW = W + FRAC_W;

  logic [W-1:0]       best_pos_q [NUM_BANDS];
  logic [W-1:0]       best_val_q [NUM_BANDS];
  logic [W-1:0]       snap_pos_q [NUM_BANDS];
  logic [W-1:0]       snap_val_q [NUM_BANDS];
  logic [QW-1:0]      dvd_q [NUM_RATIOS];
  logic [W-1:0]       rem_q [NUM_RATIOS];
  logic [RATIO_W-1:0] ratio_d [NUM_RATIOS];
  logic [W-1:0]       out_pos_q [NUM_BANDS];
  logic [W-1:0]       out_val_q [NUM_BANDS];
  logic [RATIO_W-1:0] out_ratio_q [NUM_RATIOS];
  logic               out_inv_q;

  logic [CW-1:0] x_ext;
  logic [1:0]    band;
  logic          wins;
  logic          den_zero;

  // priority band decode
  always_comb begin
    x_ext = CW'(sample_x_i);
    if (x_ext < CW'(edges_i.low)) begin
      band = BAND_0;
    end else if (x_ext < CW'(edges_i.mid)) begin
      band = BAND_1;
    end else if (x_ext < CW'(edges_i.high)) begin
      band = BAND_2;
    end else begin
      band = BAND_3;
    end
  end

  assign wins = sample_y_i > best_val_q[band];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_BANDS; k++) begin
        best_pos_q[k] <= '0;
        best_val_q[k] <= '0;
      end
    end else if (cmd_i.capture) begin
      for (int k = 0; k < NUM_BANDS; k++) begin
        best_pos_q[k] <= '0;
        best_val_q[k] <= '0;
      end
    end else if (cmd_i.search && wins) begin
      best_pos_q[band] <= sample_x_i;
      best_val_q[band] <= sample_y_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      for (int k = 0; k < NUM_BANDS; k++) begin
        snap_pos_q[k] <= best_pos_q[k];
        snap_val_q[k] <= best_val_q[k];
      end
    end
  end

  assign den_zero = (snap_val_q[BAND_2] == '0);

  // Restoring divider lanes: bands 0, 1 and 3 over band 2, one quotient bit a step.
  // The dividend register shifts out numerator bits and shifts in quotient bits.
  for (genvar l = 0; l < NUM_RATIOS; l++) begin : g_lane
    localparam int B = (l == 2) ? 3 : l;
    logic [W:0]   trial;
    logic [W:0]   diff;
    logic         ge;

    assign trial = {rem_q[l], dvd_q[l][QW-1]};
    assign diff  = trial - {1'b0, snap_val_q[BAND_2]};
    assign ge    = trial >= {1'b0, snap_val_q[BAND_2]};

    always_ff @(posedge clk_i) begin
      if (cmd_i.capture) begin
        dvd_q[l] <= {best_val_q[B], FRAC_W'(0)};
        rem_q[l] <= '0;
      end else if (cmd_i.div_step) begin
        dvd_q[l] <= {dvd_q[l][QW-2:0], ge};
        rem_q[l] <= ge ? diff[W-1:0] : trial[W-1:0];
      end
    end

    if (QW > RATIO_W) begin : g_sat
      assign ratio_d[l] = (den_zero || (|dvd_q[l][QW-1:RATIO_W])) ? '1
                                                                  : dvd_q[l][RATIO_W-1:0];
    end else begin : g_fit
      assign ratio_d[l] = den_zero ? '1 : RATIO_W'(dvd_q[l]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      for (int k = 0; k < NUM_BANDS; k++) begin
        out_pos_q[k] <= snap_pos_q[k];
        out_val_q[k] <= snap_val_q[k];
      end
      for (int j = 0; j < NUM_RATIOS; j++) begin
        out_ratio_q[j] <= ratio_d[j];
      end
      out_inv_q <= den_zero;
    end
  end

  assign peak_pos_o      = out_pos_q;
  assign peak_val_o      = out_val_q;
  assign ratio_o         = out_ratio_q;
  assign ratio_invalid_o = out_inv_q;

endmodule

// ===== hw/rtl/four_band_peak_finder.sv =====
`timescale 1ns / 1ps

// Channel    Dir  Handshake       Payload
// sample_i   in   valid / ready   sample_x, sample_y, sample_last
// result_o   out  valid / ready   peak_pos0..3, peak_val0..3, ratio_band0/1/3, ratio_invalid
// APB        in   psel / penable  band_edge_low, band_edge_mid, band_edge_high at 0x0/0x4/0x8
//
// An ordinary sample is taken every cycle while ready is high; one peak compare per sample.
// A last sample drops ready: the three restoring divider lanes, sharing band 2 as divisor,
// each produce one quotient bit per cycle, then the result is loaded into the output register.
// A result waiting in the output register does not block new samples, only the next
// completed run, which holds in the controller until the sink takes the previous one.
// Reset clears the bests, the edges and all handshake state; no clearing pass is needed.

module four_band_peak_finder import fbpf_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  fbpf_sample_if.sink        sample_i,
  fbpf_result_if.source      result_o
);

  fbpf_edges_t             edges;
  fbpf_cmd_t               cmd;
  logic [SAMPLE_WIDTH-1:0] peak_pos [NUM_BANDS];
  logic [SAMPLE_WIDTH-1:0] peak_val [NUM_BANDS];
  logic [RATIO_W-1:0]      ratio [NUM_RATIOS];
  logic                    ratio_invalid;

  fbpf_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .edges_o (edges)
  );

  fbpf_ctrl #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_i.valid),
    .in_last_i   (sample_i.sample_last),
    .in_ready_o  (sample_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .cmd_o       (cmd)
  );

  fbpf_dpath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .edges_i         (edges),
    .cmd_i           (cmd),
    .sample_x_i      (sample_i.sample_x),
    .sample_y_i      (sample_i.sample_y),
    .peak_pos_o      (peak_pos),
    .peak_val_o      (peak_val),
    .ratio_o         (ratio),
    .ratio_invalid_o (ratio_invalid)
  );

  assign result_o.peak_pos0     = peak_pos[0];
  assign result_o.peak_pos1     = peak_pos[1];
  assign result_o.peak_pos2     = peak_pos[2];
  assign result_o.peak_pos3     = peak_pos[3];
  assign result_o.peak_val0     = peak_val[0];
  assign result_o.peak_val1     = peak_val[1];
  assign result_o.peak_val2     = peak_val[2];
  assign result_o.peak_val3     = peak_val[3];
  assign result_o.ratio_band0   = ratio[0];
  assign result_o.ratio_band1   = ratio[1];
  assign result_o.ratio_band3   = ratio[2];
  assign result_o.ratio_invalid = ratio_invalid;

endmodule
